### src/ewl_pkg.sv
// ----------------------------------------------------------------------------
// ewl_pkg: shared constants and types of the energy window locator
// Clip geometry, derived widths, register map and the clip report that
// passes from the window tracker to the crop emitter.
// ----------------------------------------------------------------------------
package ewl_pkg;

   // Clip geometry.
   localparam int FramesPerClip = 98;
   localparam int WindowFrames  = 32;
   localparam int CoefsPerFrame = 40;

   // Field widths.
   localparam int CoefW    = 8;
   localparam int CropW    = 7;
   localparam int OffsetW  = 5;

   // Derived widths.
   localparam int FrameW   = (FramesPerClip > 1) ? $clog2(FramesPerClip) : 1;
   localparam int SlotW    = (WindowFrames > 1) ? $clog2(WindowFrames) : 1;
   localparam int CoefIdxW = (CoefsPerFrame > 1) ? $clog2(CoefsPerFrame) : 1;
   localparam int MagMax   = 128;
   localparam int MagW     = 9;
   localparam int EnergyW  = $clog2(CoefsPerFrame * MagMax + 1);
   localparam int SumW     = $clog2(WindowFrames * CoefsPerFrame * MagMax + 1);

   // Highest legal crop start.
   localparam int ClampHi  = (FramesPerClip > WindowFrames) ?
                             (FramesPerClip - WindowFrames) : 0;

   // Register map: the word index is paddr[2].
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam logic CsrJitterEnable = 1'b0;
   localparam logic CsrJitterOffset = 1'b1;
   localparam logic [OffsetW-1:0] JitterOffsetReset = OffsetW'(4);

   // Sent once per clip when its best window is final.
   typedef struct packed {
      logic              valid;
      logic [FrameW-1:0] best_start;
   } clip_report_type;

endpackage

### src/energy_window_locator_unit.sv
// ----------------------------------------------------------------------------
// energy_window_locator_unit: most energetic window of frames in a clip
// Sums coefficient magnitudes per frame, keeps a running window sum over a
// ring of frame energies in a memory, and reports the best crop start(s).
// ----------------------------------------------------------------------------
// Throughput: one coefficient beat per clock. Only the clip's final beat can
//    be held off, while the previous clip's crops are still being emitted.
// Crop path: a clip's report passes stages 1 and 2 and the emitter's pending
//    clip to the output; jittered crops follow one per clock while rsp_ready holds.
// Reset (synchronous, active high) clears counters, sums, the best-window
//    tracker and the registers to defaults; the energy ring is not cleared.
// ----------------------------------------------------------------------------
module energy_window_locator_unit (
   input  logic                             clock,
   input  logic                             reset,
   // Coefficient channel.
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [ewl_pkg::CoefW-1:0] req_coef,
   // Crop channel.
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ewl_pkg::CropW-1:0]        rsp_crop_start,
   output logic                             rsp_last_crop,
   // Register port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ewl_pkg::CsrAddrW-1:0]     csr_paddr,
   input  logic [ewl_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic [ewl_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                             csr_pready
);
   import ewl_pkg::*;

   // ------------------------------------------------------------------------
   // Registers. Software must write them only while the block is idle (the
   // block does not enforce this), as the pipeline reads them directly.
   // ------------------------------------------------------------------------
   logic                jitter_enable_ff, jitter_enable_in;
   logic [OffsetW-1:0]  jitter_offset_ff, jitter_offset_in;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      jitter_enable_in = jitter_enable_ff;
      jitter_offset_in = jitter_offset_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            CsrJitterEnable: jitter_enable_in = csr_pwdata[0];
            CsrJitterOffset: jitter_offset_in = csr_pwdata[OffsetW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CsrJitterEnable: csr_prdata = CsrDataW'(jitter_enable_ff);
         CsrJitterOffset: csr_prdata = CsrDataW'(jitter_offset_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Intake stage. Each accepted beat adds its magnitude to the frame energy.
   // The frame's final beat closes the frame, launches it down the window
   // pipeline and issues the ring read for the slot it will overwrite.
   // ------------------------------------------------------------------------
   logic [CoefIdxW-1:0] coef_idx_ff, coef_idx_in;
   logic [FrameW-1:0]   frame_idx_ff, frame_idx_in;
   logic [SlotW-1:0]    slot_ff, slot_in;
   logic [EnergyW-1:0]  frame_acc_ff, frame_acc_in;

   logic                accept;
   logic                frame_done;
   logic                frame_last;
   logic                clip_done_beat;
   logic [MagW-1:0]     mag;
   logic [EnergyW-1:0]  energy_sum;
   logic                emit_busy;
   logic                clip_in_flight;

   // Stage 1: frame energy closed, ring read in flight.
   logic                p1_valid_ff, p1_valid_in;
   logic [EnergyW-1:0]  p1_energy_ff, p1_energy_in;
   logic [SlotW-1:0]    p1_slot_ff, p1_slot_in;
   logic                p1_evict_ff, p1_evict_in;
   logic                p1_complete_ff, p1_complete_in;
   logic [FrameW-1:0]   p1_start_ff, p1_start_in;
   logic                p1_last_ff, p1_last_in;

   // Stage 2: window sum updated.
   logic                p2_valid_ff, p2_valid_in;
   logic [SumW-1:0]     p2_sum_ff, p2_sum_in;
   logic                p2_complete_ff, p2_complete_in;
   logic [FrameW-1:0]   p2_start_ff, p2_start_in;
   logic                p2_last_ff, p2_last_in;

   always_comb begin
      // Absolute value in nine bits so that the most negative code gives 128.
      mag = req_coef[CoefW-1] ? (MagW'(0) - MagW'(req_coef)) : MagW'(req_coef);
      energy_sum = frame_acc_ff + EnergyW'(mag);
      frame_done = coef_idx_ff == CoefIdxW'(CoefsPerFrame - 1);
      frame_last = frame_idx_ff == FrameW'(FramesPerClip - 1);
      clip_done_beat = frame_done && frame_last;

      // A clip's final beat may enter only when no earlier clip report is
      // still on its way to, or waiting in, the crop emitter.
      clip_in_flight = (p1_valid_ff && p1_last_ff) || (p2_valid_ff && p2_last_ff) ||
                       emit_busy;
      req_ready = !clip_done_beat || !clip_in_flight;
      accept    = req_valid && req_ready;
   end

   always_comb begin
      coef_idx_in    = coef_idx_ff;
      frame_idx_in   = frame_idx_ff;
      slot_in        = slot_ff;
      frame_acc_in   = frame_acc_ff;
      p1_valid_in    = 1'b0;
      p1_energy_in   = energy_sum;
      p1_slot_in     = slot_ff;
      p1_evict_in    = int'(frame_idx_ff) >= WindowFrames;
      p1_complete_in = int'(frame_idx_ff) + 1 >= WindowFrames;
      p1_start_in    = frame_idx_ff - FrameW'(WindowFrames - 1);
      p1_last_in     = frame_last;

      if (accept) begin
         if (frame_done) begin
            p1_valid_in  = 1'b1;
            coef_idx_in  = '0;
            frame_acc_in = '0;
            if (frame_last) begin
               frame_idx_in = '0;
               slot_in      = '0;
            end else begin
               frame_idx_in = frame_idx_ff + FrameW'(1);
               slot_in      = (slot_ff == SlotW'(WindowFrames - 1)) ? '0 :
                              slot_ff + SlotW'(1);
            end
         end else begin
            coef_idx_in  = coef_idx_ff + CoefIdxW'(1);
            frame_acc_in = energy_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_idx_ff  <= '0;
         frame_idx_ff <= '0;
         slot_ff      <= '0;
         frame_acc_ff <= '0;
         p1_valid_ff  <= 1'b0;
      end else begin
         coef_idx_ff  <= coef_idx_in;
         frame_idx_ff <= frame_idx_in;
         slot_ff      <= slot_in;
         frame_acc_ff <= frame_acc_in;
         p1_valid_ff  <= p1_valid_in;
      end
      p1_energy_ff   <= p1_energy_in;
      p1_slot_ff     <= p1_slot_in;
      p1_evict_ff    <= p1_evict_in;
      p1_complete_ff <= p1_complete_in;
      p1_start_ff    <= p1_start_in;
      p1_last_ff     <= p1_last_in;
   end

   // ------------------------------------------------------------------------
   // Energy ring. One synchronous memory: the read is issued with the
   // frame's final beat and the write of the new energy lands in the next
   // cycle. When a read and a write meet on the same slot at the same edge,
   // the written energy is forwarded in place of the stale read data.
   // Every slot is written within a clip before it is evicted, so the ring
   // needs no clearing.
   // ------------------------------------------------------------------------
   logic [EnergyW-1:0] ring_mem [WindowFrames];
   logic [EnergyW-1:0] ring_rd_ff;
   logic               ring_rd_en;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [EnergyW-1:0] fwd_data_ff;
   logic [EnergyW-1:0] evicted;

   assign ring_rd_en = accept && frame_done;
   assign fwd_hit_in = ring_rd_en && p1_valid_ff && (p1_slot_ff == slot_ff);

   always_ff @(posedge clock) begin
      if (ring_rd_en) begin
         ring_rd_ff <= ring_mem[slot_ff];
      end
      if (p1_valid_ff) begin
         ring_mem[p1_slot_ff] <= p1_energy_ff;
      end
      fwd_hit_ff  <= fwd_hit_in;
      fwd_data_ff <= p1_energy_ff;
   end

   assign evicted = fwd_hit_ff ? fwd_data_ff : ring_rd_ff;

   // ------------------------------------------------------------------------
   // Stage 2: running window sum. The evicted energy leaves the window once
   // the ring has wrapped. The sum restarts from zero after a clip's final
   // frame, while that frame's sum travels on to the best-window compare.
   // ------------------------------------------------------------------------
   logic [SumW-1:0] window_sum_ff, window_sum_in;
   logic [SumW-1:0] sum_new;

   always_comb begin
      sum_new = window_sum_ff - (p1_evict_ff ? SumW'(evicted) : SumW'(0)) +
                SumW'(p1_energy_ff);
      window_sum_in  = window_sum_ff;
      p2_valid_in    = p1_valid_ff;
      p2_sum_in      = sum_new;
      p2_complete_in = p1_complete_ff;
      p2_start_in    = p1_start_ff;
      p2_last_in     = p1_last_ff;
      if (p1_valid_ff) begin
         window_sum_in = p1_last_ff ? '0 : sum_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_sum_ff <= '0;
         p2_valid_ff   <= 1'b0;
      end else begin
         window_sum_ff <= window_sum_in;
         p2_valid_ff   <= p2_valid_in;
      end
      p2_sum_ff      <= p2_sum_in;
      p2_complete_ff <= p2_complete_in;
      p2_start_ff    <= p2_start_in;
      p2_last_ff     <= p2_last_in;
   end

   // ------------------------------------------------------------------------
   // Stage 3: best-window tracker. Only a strictly larger sum replaces the
   // best, so ties keep the earliest start; the first full window is always
   // taken. On the clip's final frame the result goes to the emitter and the
   // tracker rearms. A clip shorter than the window reports start zero.
   // ------------------------------------------------------------------------
   logic              best_valid_ff, best_valid_in;
   logic [SumW-1:0]   best_sum_ff, best_sum_in;
   logic [FrameW-1:0] best_start_ff, best_start_in;
   logic              take;
   clip_report_type   report;

   always_comb begin
      take = p2_valid_ff && p2_complete_ff &&
             (!best_valid_ff || (p2_sum_ff > best_sum_ff));
      best_valid_in = best_valid_ff;
      best_sum_in   = best_sum_ff;
      best_start_in = best_start_ff;
      report.valid      = p2_valid_ff && p2_last_ff;
      report.best_start = take ? p2_start_ff : best_start_ff;
      if (p2_valid_ff && p2_last_ff) begin
         best_valid_in = 1'b0;
         best_sum_in   = '0;
         best_start_in = '0;
      end else if (take) begin
         best_valid_in = 1'b1;
         best_sum_in   = p2_sum_ff;
         best_start_in = p2_start_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff    <= 1'b0;
         best_sum_ff      <= '0;
         best_start_ff    <= '0;
         jitter_enable_ff <= 1'b0;
         jitter_offset_ff <= JitterOffsetReset;
      end else begin
         best_valid_ff    <= best_valid_in;
         best_sum_ff      <= best_sum_in;
         best_start_ff    <= best_start_in;
         jitter_enable_ff <= jitter_enable_in;
         jitter_offset_ff <= jitter_offset_in;
      end
   end

   // ------------------------------------------------------------------------
   // Crop emitter: one beat for the best start, or three with jitter on
   // (best, best minus offset, best plus offset), each clamped to the clip.
   // ------------------------------------------------------------------------
   ewl_crop_emit u_crop_emit (
      .clock          (clock),
      .reset          (reset),
      .clip           (report),
      .jitter_enable  (jitter_enable_ff),
      .jitter_offset  (jitter_offset_ff),
      .busy           (emit_busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_crop_start (rsp_crop_start),
      .rsp_last_crop  (rsp_last_crop)
   );

endmodule

### src/ewl_crop_emit.sv
// ----------------------------------------------------------------------------
// ewl_crop_emit: turns a clip's best start into one or three crop beats
// Holds one pending clip, forms the clamped crop starts one per cycle while
// the output register is empty or taken, and drives the result channel through it.
// ----------------------------------------------------------------------------
module ewl_crop_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  ewl_pkg::clip_report_type      clip,
   input  logic                          jitter_enable,
   input  logic [ewl_pkg::OffsetW-1:0]   jitter_offset,
   output logic                          busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ewl_pkg::CropW-1:0]     rsp_crop_start,
   output logic                          rsp_last_crop
);
   import ewl_pkg::*;

   localparam int CalcW = ((FrameW > OffsetW) ? FrameW : OffsetW) + 2;
   localparam logic [1:0] CropBest = 2'd0;
   localparam logic [1:0] CropLow  = 2'd1;
   localparam logic [1:0] CropHigh = 2'd2;

   function automatic logic [CropW-1:0] clamp_crop(input logic signed [CalcW-1:0] s);
      logic [CropW-1:0] r;
      if (s > signed'(CalcW'(ClampHi))) begin
         r = CropW'(ClampHi);
      end else if (s < 0) begin
         r = '0;
      end else begin
         r = s[CropW-1:0];
      end
      return r;
   endfunction

   logic                  pend_valid_ff, pend_valid_in;
   logic [FrameW-1:0]     pend_best_ff, pend_best_in;
   logic                  pend_jit_ff, pend_jit_in;
   logic [OffsetW-1:0]    pend_off_ff, pend_off_in;
   logic [1:0]            crop_sel_ff, crop_sel_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CropW-1:0]      out_crop_ff, out_crop_in;
   logic                  out_last_ff, out_last_in;

   logic                  load;
   logic signed [CalcW-1:0] best_s, off_s, crop_s;
   logic                  crop_last;

   always_comb begin
      best_s = signed'(CalcW'(pend_best_ff));
      off_s  = signed'(CalcW'(pend_off_ff));
      case (crop_sel_ff)
         CropBest: crop_s = best_s;
         CropLow:  crop_s = best_s - off_s;
         CropHigh: crop_s = best_s + off_s;
         default:  crop_s = best_s;
      endcase
      crop_last = !pend_jit_ff || (crop_sel_ff == CropHigh);
      load = pend_valid_ff && (!out_valid_ff || rsp_ready);
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_best_in  = pend_best_ff;
      pend_jit_in   = pend_jit_ff;
      pend_off_in   = pend_off_ff;
      crop_sel_in   = crop_sel_ff;
      out_valid_in  = out_valid_ff;
      out_crop_in   = out_crop_ff;
      out_last_in   = out_last_ff;

      if (load) begin
         out_valid_in = 1'b1;
         out_crop_in  = clamp_crop(crop_s);
         out_last_in  = crop_last;
         if (crop_last) begin
            pend_valid_in = 1'b0;
         end else begin
            crop_sel_in = (crop_sel_ff == CropBest) ? CropLow : CropHigh;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      // The intake never lets a new clip in while one is still pending.
      if (clip.valid) begin
         pend_valid_in = 1'b1;
         pend_best_in  = clip.best_start;
         pend_jit_in   = jitter_enable;
         pend_off_in   = jitter_offset;
         crop_sel_in   = CropBest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         crop_sel_ff   <= CropBest;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         crop_sel_ff   <= crop_sel_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_best_ff <= pend_best_in;
      pend_jit_ff  <= pend_jit_in;
      pend_off_ff  <= pend_off_in;
      out_crop_ff  <= out_crop_in;
      out_last_ff  <= out_last_in;
   end

   assign busy           = pend_valid_ff;
   assign rsp_valid      = out_valid_ff;
   assign rsp_crop_start = out_crop_ff;
   assign rsp_last_crop  = out_last_ff;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the energy window locator
// Streams whole clips of coefficient beats into the unit. A beat-level
// tracker of frame energies and window sums predicts the crop beats. A short
// table of hand-built clips comes first, some with crop starts typed in, and
// is followed by random clips. Both channels idle at random, and the jitter
// registers are reprogrammed between clips over the register port.
// ----------------------------------------------------------------------------
module tb_top;
   import ewl_pkg::*;

   localparam int ClockPeriod   = 8;
   localparam int ResetCycles   = 12;
   localparam int DirectedClips = 13;
   localparam int RandomClips   = 34;
   // The last few random clips run without any idling on either side.
   localparam int QuietClips    = 4;
   localparam int BeatsPerClip  = FramesPerClip * CoefsPerFrame;
   // A pause after the last crop beat is back, before the registers are touched.
   localparam int SettleCycles  = 8;
   // The slowest legal run has the longest idle gap before every beat. The
   // limit is three times that, which also leaves room for drains and stalls.
   localparam int CycleLimit    = (DirectedClips + RandomClips) * BeatsPerClip * 7 * 3;

   localparam logic [CsrAddrW-1:0] AddrJitterEnable = CsrAddrW'(4 * int'(CsrJitterEnable));
   localparam logic [CsrAddrW-1:0] AddrJitterOffset = CsrAddrW'(4 * int'(CsrJitterOffset));

   // Energy profile of a clip. Each frame gets a magnitude level. A noise
   // frame instead takes raw random coefficients.
   typedef enum logic [2:0] {
      SHAPE_NOISE,
      SHAPE_FLAT,
      SHAPE_PEAK,
      SHAPE_TWIN,
      SHAPE_RAMP_UP,
      SHAPE_RAMP_DOWN,
      SHAPE_PATCHY
   } clip_shape_type;

   typedef struct packed {
      bit                 set_regs;
      bit                 jit_en;
      logic [OffsetW-1:0] jit_off;
      clip_shape_type     shape;
      int                 level;
      int                 floor_lvl;
      int                 spot_a;
      int                 spot_b;
      bit                 typed;
      int                 crop0;
      int                 crop1;
      int                 crop2;
   } clip_plan_type;

   typedef struct packed {
      logic [CropW-1:0] start;
      logic             last;
   } crop_beat_type;

   // ------------------------------------------------------------------------
   // Hand-built clips. Where the best start is obvious, the crop starts are
   // typed in and checked as given. Those clips have silent frames around one
   // or two hot frames, flat clips where every window ties, and ramps. The
   // remaining rows go through the tracker.
   // Columns: set_regs, jit_en, jit_off, shape, level, floor, spot_a, spot_b,
   //          typed, crop0, crop1, crop2.
   // ------------------------------------------------------------------------
   clip_plan_type directed_plan [DirectedClips] = '{
      // Straight out of reset: an all-zero clip with the default registers.
      // Every window ties at zero, so the first window holds at start 0.
      '{1'b0, 1'b0, 5'd4,  SHAPE_FLAT,      0,   0, 0,  0,  1'b1, 0,  0,  0},
      // Every coefficient is the most negative code. Ties again at start 0.
      '{1'b1, 1'b1, 5'd4,  SHAPE_FLAT,      128, 0, 0,  0,  1'b1, 0,  0,  4},
      // A hot last frame. Only the final window sees it, and +16 clamps high.
      '{1'b1, 1'b1, 5'd16, SHAPE_PEAK,      127, 0, 97, 0,  1'b1, 66, 50, 66},
      // A hot first frame. Only window 0 sees it, and -16 clamps to zero.
      '{1'b1, 1'b1, 5'd16, SHAPE_PEAK,      127, 0, 0,  0,  1'b1, 0,  0,  16},
      // A peak at frame 40. Windows 9 to 40 tie, and the earliest one wins.
      '{1'b1, 1'b1, 5'd0,  SHAPE_PEAK,      128, 0, 40, 0,  1'b1, 9,  9,  9},
      // The widest offset the field holds. The low crop clamps to zero.
      '{1'b1, 1'b1, 5'd31, SHAPE_PEAK,      64,  0, 50, 0,  1'b1, 19, 0,  50},
      // Rising energy: each later window is strictly larger.
      '{1'b1, 1'b0, 5'd31, SHAPE_RAMP_UP,   0,   0, 0,  0,  1'b1, 66, 0,  0},
      // Falling energy: the first window stays best.
      '{1'b1, 1'b1, 5'd1,  SHAPE_RAMP_DOWN, 0,   0, 0,  0,  1'b1, 0,  0,  1},
      // Two equal peaks far apart. The window ending on the second one only
      // ties, so start 9 is kept.
      '{1'b1, 1'b1, 5'd5,  SHAPE_TWIN,      100, 0, 40, 80, 1'b1, 9,  4,  14},
      '{1'b1, 1'b0, 5'd0,  SHAPE_FLAT,      127, 0, 0,  0,  1'b1, 0,  0,  0},
      // The rows from here on are checked against the tracker.
      '{1'b1, 1'b1, 5'd16, SHAPE_NOISE,     0,   0, 0,  0,  1'b0, 0,  0,  0},
      '{1'b1, 1'b1, 5'd2,  SHAPE_TWIN,      90,  3, 20, 70, 1'b0, 0,  0,  0},
      '{1'b1, 1'b1, 5'd16, SHAPE_PATCHY,    0,   0, 0,  0,  1'b0, 0,  0,  0}
   };

   // DUT ports.
   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [CoefW-1:0]   req_coef;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b1;
   logic [CropW-1:0]          rsp_crop_start;
   logic                      rsp_last_crop;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CsrAddrW-1:0]       csr_paddr;
   logic [CsrDataW-1:0]       csr_pwdata;
   logic [CsrDataW-1:0]       csr_prdata;
   logic                      csr_pready;

   energy_window_locator_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_coef       (req_coef),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_crop_start (rsp_crop_start),
      .rsp_last_crop  (rsp_last_crop),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Window tracker. It copies the unit's state at the unit's own widths. It
   // is advanced on every accepted coefficient beat, and when a clip
   // completes on an untyped row it queues the crop beats that the unit must send.
   // ------------------------------------------------------------------------
   logic [CoefIdxW-1:0] coef_cnt;
   logic [FrameW-1:0]   frame_cnt;
   logic [EnergyW-1:0]  frame_acc;
   logic [EnergyW-1:0]  energy_ring [WindowFrames];
   logic [SumW-1:0]     win_sum;
   logic [SumW-1:0]     best_sum;
   bit                  best_seen;
   logic [FrameW-1:0]   best_at;

   // Register shadows. They are written only while the unit is idle.
   bit                  shadow_jit_en;
   logic [OffsetW-1:0]  shadow_jit_off;

   // On typed rows the table supplies the crops, so the tracker only keeps
   // its state up to date and queues nothing.
   bit                  predict_crops;
   crop_beat_type       pending_crops [$];

   // Per-frame magnitude levels of the clip being sent. -1 marks noise.
   int                  frame_level [FramesPerClip];

   bit                  sender_idles;
   bit                  sink_stalls;
   int                  stall_left = 0;

   int                  errors;
   int                  beats_accepted;
   int                  crops_checked;
   int                  clips_sent;
   int                  jittered_clips;
   int                  csr_writes;
   int                  cycle_count;

   function automatic void clear_clip_state();
      coef_cnt  = '0;
      frame_cnt = '0;
      frame_acc = '0;
      win_sum   = '0;
      best_sum  = '0;
      best_seen = 1'b0;
      best_at   = '0;
   endfunction

   function automatic logic [CropW-1:0] clamp_crop(input int s);
      if (s > ClampHi) s = ClampHi;
      if (s < 0) s = 0;
      return CropW'(s);
   endfunction

   function automatic void queue_crop(input int s, input bit last);
      pending_crops.push_back(crop_beat_type'{start: clamp_crop(s), last: last});
   endfunction

   function automatic void advance_energy_tracker(input logic signed [CoefW-1:0] c);
      int                 mag;
      int                 slot;
      int                 b;
      int                 off;
      logic [EnergyW-1:0] energy;
      // Taken as a 9-bit magnitude, -128 adds a full 128.
      mag = (c < 0) ? -int'(c) : int'(c);
      frame_acc = frame_acc + EnergyW'(mag);
      if (int'(coef_cnt) + 1 < CoefsPerFrame) begin
         coef_cnt = coef_cnt + 1'b1;
      end else begin
         energy    = frame_acc;
         frame_acc = '0;
         coef_cnt  = '0;
         slot = int'(frame_cnt) % WindowFrames;
         // The oldest frame drops out once the window is full.
         if (int'(frame_cnt) >= WindowFrames) win_sum = win_sum - SumW'(energy_ring[slot]);
         energy_ring[slot] = energy;
         win_sum = win_sum + SumW'(energy);
         // The first full window always takes the lead. After that, only a
         // strictly larger sum replaces it, so ties keep the earlier start.
         if (int'(frame_cnt) + 1 >= WindowFrames && (!best_seen || win_sum > best_sum)) begin
            best_sum  = win_sum;
            best_at   = FrameW'(int'(frame_cnt) + 1 - WindowFrames);
            best_seen = 1'b1;
         end
         if (int'(frame_cnt) + 1 < FramesPerClip) begin
            frame_cnt = frame_cnt + 1'b1;
         end else begin
            b   = int'(best_at);
            off = int'(shadow_jit_off);
            if (predict_crops) begin
               if (shadow_jit_en) begin
                  queue_crop(b, 1'b0);
                  queue_crop(b - off, 1'b0);
                  queue_crop(b + off, 1'b1);
               end else begin
                  queue_crop(b, 1'b1);
               end
            end
            clear_clip_state();
         end
      end
   endfunction

   function automatic void check_crop_beat();
      crop_beat_type want;
      if (pending_crops.size() == 0) begin
         $display("%0t: crop beat with none pending: crop_start %0d last_crop %0d",
                  $time, rsp_crop_start, rsp_last_crop);
         errors++;
      end else begin
         want = pending_crops.pop_front();
         if (rsp_crop_start !== want.start) begin
            $display("%0t: crop_start mismatch: expected %0d, got %0d",
                     $time, want.start, rsp_crop_start);
            errors++;
         end
         if (rsp_last_crop !== want.last) begin
            $display("%0t: last_crop mismatch: expected %0d, got %0d",
                     $time, want.last, rsp_last_crop);
            errors++;
         end
         crops_checked++;
      end
   endfunction

   // Both channels are sampled at the rising edge, with the values from
   // before the edge. The tracker runs before the checker, so a beat that
   // closes a clip has its crops queued first.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            advance_energy_tracker(req_coef);
            beats_accepted++;
         end
         if (rsp_valid && rsp_ready) check_crop_beat();
      end
   end

   // Watchdog. It catches a hung handshake and crops that never arrive.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout after %0d cycles, %0d crop beats still pending",
                  $time, cycle_count, pending_crops.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Crop sink. It drops ready for bursts of random length. The bursts are
   // not tied to rsp_valid, so they land before, inside and after the
   // three-beat jittered reports.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Register port. Every task enters and leaves at a falling edge.
   // ------------------------------------------------------------------------
   task automatic csr_write(input logic [CsrAddrW-1:0] addr, input logic [CsrDataW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_writes++;
   endtask

   task automatic csr_check(input logic [CsrAddrW-1:0] addr, input logic [CsrDataW-1:0] want);
      logic [CsrDataW-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want) begin
         $display("%0t: register read at address %0d: expected %0d, got %0d",
                  $time, addr, want, got);
         errors++;
      end
   endtask

   task automatic program_jitter(input bit en, input logic [OffsetW-1:0] off);
      csr_write(AddrJitterEnable, CsrDataW'(en));
      csr_write(AddrJitterOffset, CsrDataW'(off));
      shadow_jit_en  = en;
      shadow_jit_off = off;
      csr_check(AddrJitterEnable, CsrDataW'(en));
      csr_check(AddrJitterOffset, CsrDataW'(off));
   endtask

   // Holds the sender until every queued crop has come back, then lets the
   // unit settle.
   task automatic wait_drained();
      while (pending_crops.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Coefficient sender. Valid rises only at a falling edge and is lowered
   // only at the start of an idle burst or before a drain. A valid that
   // stays high for the next beat is therefore never written twice in one
   // step.
   // ------------------------------------------------------------------------
   task automatic send_beat(input logic signed [CoefW-1:0] c);
      if (sender_idles && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_coef  <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic void fill_levels(input clip_plan_type p);
      for (int f = 0; f < FramesPerClip; f++) begin
         case (p.shape)
            SHAPE_NOISE:     frame_level[f] = -1;
            SHAPE_FLAT:      frame_level[f] = p.level;
            SHAPE_PEAK:      frame_level[f] = (f == p.spot_a) ? p.level : p.floor_lvl;
            SHAPE_TWIN:      frame_level[f] = (f == p.spot_a || f == p.spot_b) ?
                                              p.level : p.floor_lvl;
            SHAPE_RAMP_UP:   frame_level[f] = f * MagMax / (FramesPerClip - 1);
            SHAPE_RAMP_DOWN: frame_level[f] = (FramesPerClip - 1 - f) * MagMax /
                                              (FramesPerClip - 1);
            default:         frame_level[f] = $urandom_range(0, MagMax);
         endcase
      end
   endfunction

   // A levelled frame uses exact magnitudes with a random sign. That keeps
   // frame energies known, so ties stay ties. Level 128 has only one code.
   function automatic logic signed [CoefW-1:0] make_coef(input int f);
      int lvl;
      lvl = frame_level[f];
      if (lvl < 0) return CoefW'($urandom);
      if (lvl >= MagMax) return {1'b1, {(CoefW - 1){1'b0}}};
      if ($urandom_range(0, 1) == 1) return CoefW'(-lvl);
      return CoefW'(lvl);
   endfunction

   function automatic clip_plan_type random_plan();
      clip_plan_type p;
      p.set_regs = ($urandom_range(0, 2) == 0);
      p.jit_en   = 1'($urandom_range(0, 1));
      // The offset extremes come up often. Any 5-bit value is legal.
      case ($urandom_range(0, 3))
         0:       p.jit_off = '0;
         1:       p.jit_off = OffsetW'(16);
         2:       p.jit_off = '1;
         default: p.jit_off = OffsetW'($urandom_range(0, 31));
      endcase
      p.shape     = clip_shape_type'(3'($urandom_range(0, 6)));
      p.level     = (p.shape == SHAPE_FLAT) ? $urandom_range(0, MagMax) :
                                              $urandom_range(21, MagMax);
      p.floor_lvl = $urandom_range(0, 20);
      p.spot_a    = $urandom_range(0, FramesPerClip - 1);
      p.spot_b    = $urandom_range(0, FramesPerClip - 1);
      p.typed     = 1'b0;
      p.crop0     = 0;
      p.crop1     = 0;
      p.crop2     = 0;
      return p;
   endfunction

   // One whole clip. Registers are reprogrammed only once the previous clip's
   // crops are all back. Without a drain, the next clip starts while the last
   // report may still be going out, and that is where the unit holds off the
   // clip's final beat.
   task automatic run_clip(input clip_plan_type p, input bit drain);
      if (drain) begin
         // Valid is still up from the previous clip's final beat.
         req_valid <= 1'b0;
         wait_drained();
      end
      if (p.set_regs) program_jitter(p.jit_en, p.jit_off);
      fill_levels(p);
      predict_crops = !p.typed;
      if (p.typed) begin
         if (shadow_jit_en) begin
            queue_crop(p.crop0, 1'b0);
            queue_crop(p.crop1, 1'b0);
            queue_crop(p.crop2, 1'b1);
         end else begin
            queue_crop(p.crop0, 1'b1);
         end
      end
      if (shadow_jit_en) jittered_clips++;
      for (int f = 0; f < FramesPerClip; f++) begin
         for (int k = 0; k < CoefsPerFrame; k++) begin
            send_beat(make_coef(f));
         end
      end
      clips_sent++;
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      clip_plan_type plan;
      bit            drain;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_coef       = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      errors         = 0;
      beats_accepted = 0;
      crops_checked  = 0;
      clips_sent     = 0;
      jittered_clips = 0;
      csr_writes     = 0;
      cycle_count    = 0;
      predict_crops  = 1'b1;
      sender_idles   = 1'b0;
      sink_stalls    = 1'b0;
      shadow_jit_en  = 1'b0;
      shadow_jit_off = JitterOffsetReset;
      clear_clip_state();

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset must leave jitter off and the offset at its default.
      csr_check(AddrJitterEnable, '0);
      csr_check(AddrJitterOffset, CsrDataW'(JitterOffsetReset));

      // Hand-built clips, each started only after the last report drained.
      sender_idles = 1'b1;
      sink_stalls  = 1'b1;
      for (int i = 0; i < DirectedClips; i++) begin
         run_clip(directed_plan[i], 1'b1);
      end

      // Random clips. The idle pattern changes from clip to clip, so some
      // clips run with no idling at all. The final clips run at full rate,
      // back to back with no drain and no register traffic.
      for (int i = 0; i < RandomClips; i++) begin
         plan = random_plan();
         if (i >= RandomClips - QuietClips) begin
            sender_idles  = 1'b0;
            sink_stalls   = 1'b0;
            plan.set_regs = 1'b0;
            drain         = 1'b0;
         end else begin
            sender_idles = ($urandom_range(0, 2) != 0);
            sink_stalls  = ($urandom_range(0, 2) != 0);
            drain        = plan.set_regs || ($urandom_range(0, 2) == 0);
         end
         run_clip(plan, drain);
      end
      req_valid <= 1'b0;

      wait_drained();

      $display("Sent %0d clips (%0d coefficient beats, %0d with three jittered crops).",
               clips_sent, beats_accepted, jittered_clips);
      $display("Checked %0d crop beats, with %0d register writes between clips.",
               crops_checked, csr_writes);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
